[rtl/mlc_pkg.sv]
package mlc_pkg;

  // Field widths fixed by the item format.
  localparam int KeyW   = 64;
  localparam int OutValW = 32;
  localparam int LevelW = 2;

  // Request kinds.
  typedef enum logic {
    REQ_LOOKUP = 1'b0,
    REQ_FILL   = 1'b1
  } req_kind_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic capture;   // latch the incoming item
    logic rd;        // issue reads to every level
    logic eval;      // compare tags and decide, registered
    logic wr;        // write back the selected levels
    logic clr;       // one step of the clearing pass
  } mlc_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic clr_done;
  } mlc_sts_t;

endpackage

[rtl/multilevel_two_way_lookup_cache_top.sv]
// Multilevel two-way lookup cache. Each item (lookup or fill) is captured, its set
// is read in every level memory and the tags are compared; the result is shown and
// held while the output stalls. When it is taken, levels down to the hit level are
// written back, all of them on a fill miss and none on a lookup miss. After reset a
// clearing pass wipes every level's sets while in_tready stays low.
module multilevel_two_way_lookup_cache_top #(
  parameter int LEVELS = 3,
  parameter int BASE_ORDER = 6,
  parameter int VALUE_WIDTH = 32
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [95:0]  in_tdata,   // key[63:0], fill_value[95:64]
  input  logic         in_tuser,   // req_type
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [39:0]  out_tdata,  // hit[0], value[32:1], hit_level[34:33], zero fill
  output logic         out_tuser
);
  import mlc_pkg::*;

  mlc_cmd_t cmd;
  mlc_sts_t sts;
  logic res_hit;
  logic [OutValW-1:0] res_value;
  logic [LevelW-1:0] res_level;

  mlc_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n), .in_tvalid(in_tvalid), .in_tready(in_tready),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .cmd(cmd), .sts(sts)
  );

  mlc_datapath #(.LEVELS(LEVELS), .BASE_ORDER(BASE_ORDER),
                 .VALUE_WIDTH(VALUE_WIDTH)) u_dp (
    .clk(clk), .rst_n(rst_n), .cmd(cmd), .sts(sts), .in_fill(in_tuser),
    .in_key(in_tdata[63:0]), .in_fval(in_tdata[95:64]),
    .res_hit(res_hit), .res_value(res_value), .res_level(res_level)
  );

  assign out_tdata = {5'b0, res_level, res_value, res_hit};
  assign out_tuser = 1'b0;

endmodule

[rtl/mlc_ram.sv]
module mlc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // One write port, one registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[rtl/mlc_level.sv]
module mlc_level #(
  parameter int ORDER = 6,
  parameter int VALUE_WIDTH = 32
) (
  input  logic                          clk,
  input  logic [ORDER-1:0]              raddr,
  input  logic                          we,
  input  logic [ORDER-1:0]              waddr,
  input  logic [1+2*(65+VALUE_WIDTH)-1:0] wdata,
  output logic [1+2*(65+VALUE_WIDTH)-1:0] rdata
);

  // One row per set: MRU bit, then for each way a valid bit, key and value.
  localparam int RowW = 1 + 2 * (65 + VALUE_WIDTH);

  mlc_ram #(.WIDTH(RowW), .DEPTH(2 ** ORDER)) u_ram (
    .clk(clk), .we(we), .waddr(waddr), .wdata(wdata),
    .raddr(raddr), .rdata(rdata)
  );

endmodule

[rtl/mlc_datapath.sv]
module mlc_datapath #(
  parameter int LEVELS = 3,
  parameter int BASE_ORDER = 6,
  parameter int VALUE_WIDTH = 32
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  mlc_pkg::mlc_cmd_t          cmd,
  output mlc_pkg::mlc_sts_t          sts,
  input  logic                       in_fill,
  input  logic [mlc_pkg::KeyW-1:0]   in_key,
  input  logic [mlc_pkg::OutValW-1:0] in_fval,
  output logic                       res_hit,
  output logic [mlc_pkg::OutValW-1:0] res_value,
  output logic [mlc_pkg::LevelW-1:0] res_level
);
  import mlc_pkg::*;

  localparam int EntW = 65 + VALUE_WIDTH;
  localparam int RowW = 1 + 2 * EntW;
  localparam int MaxOrd = BASE_ORDER + 3 * (LEVELS - 1);
  localparam int LvlW = (LEVELS > 1) ? $clog2(LEVELS + 1) : 1;

  logic                   fill_r;
  logic [KeyW-1:0]        key_r;
  logic [VALUE_WIDTH-1:0] fval_r;
  logic [MaxOrd:0]        clr_cnt_r;
  logic [RowW-1:0]        row   [LEVELS];
  logic [RowW-1:0]        wrow  [LEVELS];
  logic [LEVELS-1:0]      hitv, wayv, lvl_we;
  logic                   dec_any_r, dec_way_r;
  logic [LvlW-1:0]        dec_lvl_r;
  logic [VALUE_WIDTH-1:0] dec_val_r;
  logic                   hit_any;
  logic [LvlW-1:0]        hit_lvl;
  logic                   hit_way;
  logic [VALUE_WIDTH-1:0] hit_val;
  logic [RowW-1:0]        dec_row_r [LEVELS];

  // Item capture and clearing counter.
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      fill_r <= in_fill;
      key_r  <= in_key;
      fval_r <= VALUE_WIDTH'(in_fval);
    end
    if (!rst_n) begin
      clr_cnt_r <= '0;
    end else if (cmd.clr) begin
      clr_cnt_r <= clr_cnt_r + 1'b1;
    end else if (cmd.capture) begin
      clr_cnt_r <= '0;
    end
  end
  assign sts.clr_done = clr_cnt_r[MaxOrd];

  // Level k is written when it hit, or lies above the hit level; never on a lookup miss.
  function automatic logic dec_any_r_or_fill(input int k);
    return (dec_lvl_r >= LvlW'(k)) && (dec_any_r || fill_r);
  endfunction

  // One memory per level, read at the key's set.
  for (genvar k = 0; k < LEVELS; k++) begin : g_lvl
    localparam int Ord = BASE_ORDER + 3 * k;
    logic [Ord-1:0] ra, wa;
    logic [EntW-1:0] e0, e1;
    logic mru;
    logic h0, h1;
    assign ra  = cmd.capture ? in_key[Ord-1:0] : key_r[Ord-1:0];
    assign wa  = cmd.clr ? clr_cnt_r[Ord-1:0] : key_r[Ord-1:0];
    assign mru = row[k][RowW-1];
    assign e1  = row[k][2*EntW-1:EntW];
    assign e0  = row[k][EntW-1:0];
    // Way hit: valid and key match, MRU way wins ties.
    assign h0 = e0[EntW-1] && (e0[EntW-2:VALUE_WIDTH] == key_r);
    assign h1 = e1[EntW-1] && (e1[EntW-2:VALUE_WIDTH] == key_r);
    assign hitv[k] = h0 | h1;
    assign wayv[k] = mru ? (h1 ? 1'b1 : 1'b0) : (h0 ? 1'b0 : 1'b1);
    assign lvl_we[k] = cmd.clr || (cmd.wr && dec_any_r_or_fill(k));
    mlc_level #(.ORDER(Ord), .VALUE_WIDTH(VALUE_WIDTH)) u_level (
      .clk(clk), .raddr(ra), .we(lvl_we[k]), .waddr(wa),
      .wdata(cmd.clr ? RowW'(0) : wrow[k]), .rdata(row[k])
    );
  end

  // Pick the first hitting level.
  always_comb begin
    hit_any = 1'b0;
    hit_lvl = LvlW'(LEVELS);
    hit_way = 1'b0;
    for (int k = LEVELS - 1; k >= 0; k--) begin
      if (hitv[k]) begin
        hit_any = 1'b1;
        hit_lvl = LvlW'(k);
        hit_way = wayv[k];
      end
    end
    hit_val = fval_r;
    for (int k = 0; k < LEVELS; k++) begin
      if (hit_any && hit_lvl == LvlW'(k)) begin
        hit_val = hit_way ? row[k][EntW+VALUE_WIDTH-1:EntW]
                          : row[k][VALUE_WIDTH-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.eval) begin
      dec_any_r <= hit_any;
      dec_lvl_r <= hit_lvl;
      dec_way_r <= hit_way;
      dec_val_r <= hit_val;
      for (int k = 0; k < LEVELS; k++) dec_row_r[k] <= row[k];
    end
  end

  // Rows written back: hit level updates MRU only, shallower levels refill LRU.
  always_comb begin
    for (int k = 0; k < LEVELS; k++) begin
      wrow[k] = dec_row_r[k];
      if (dec_lvl_r == LvlW'(k)) begin
        wrow[k][RowW-1] = dec_way_r;
      end else if (!dec_row_r[k][RowW-1]) begin
        wrow[k][RowW-1] = 1'b1;
        wrow[k][2*EntW-1:EntW] = {1'b1, key_r, dec_val_r};
      end else begin
        wrow[k][RowW-1] = 1'b0;
        wrow[k][EntW-1:0] = {1'b1, key_r, dec_val_r};
      end
    end
  end

  // Result: a lookup miss returns zero.
  assign res_hit   = dec_any_r;
  assign res_value = (dec_any_r || fill_r) ? OutValW'(dec_val_r) : '0;
  assign res_level = LevelW'(dec_lvl_r);

endmodule

[rtl/mlc_ctrl.sv]
module mlc_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  output logic              in_tready,
  output logic              out_tvalid,
  input  logic              out_tready,
  output mlc_pkg::mlc_cmd_t cmd,
  input  mlc_pkg::mlc_sts_t sts
);
  import mlc_pkg::*;

  typedef enum logic [4:0] {
    S_CLEAR = 5'b00001,
    S_IDLE  = 5'b00010,
    S_READ  = 5'b00100,
    S_EVAL  = 5'b01000,
    S_OUT   = 5'b10000
  } state_t;

  state_t state_r, state_nxt;

  // Clear all sets after reset, then capture, read, decide, present and write back.
  always_comb begin
    state_nxt = state_r;
    cmd = '0;
    unique case (state_r)
      S_CLEAR: begin
        cmd.clr = !sts.clr_done;
        if (sts.clr_done) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        cmd.capture = 1'b1;
        cmd.clr = 1'b0;
        if (in_tvalid) state_nxt = S_READ;
      end
      S_READ: state_nxt = S_EVAL;
      S_EVAL: begin
        cmd.eval = 1'b1;
        state_nxt = S_OUT;
      end
      S_OUT: begin
        if (out_tready) begin
          cmd.wr = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_CLEAR;
    endcase
  end

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = (state_r == S_OUT);

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= S_CLEAR;
    else state_r <= state_nxt;
  end

  a_onehot: assert property (@(posedge clk) disable iff (!rst_n) $onehot(state_r))
    else $error("state not one-hot");
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid) else $error("result dropped");
  a_no_accept: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> !in_tready) else $error("accept while busy");

endmodule

[verif/tb_multilevel_two_way_lookup_cache_top.sv]
module tb_multilevel_two_way_lookup_cache_top;
  timeunit 1ns;
  timeprecision 1ps;

  import mlc_pkg::*;

  localparam int NumLevels = 3;
  localparam int BaseOrder = 6;
  localparam int NumSets = ((8 ** NumLevels - 1) / 7) << BaseOrder;
  localparam int CycleLimit = 400000;

  // Same bit order as out_tdata: hit in the lowest bit.
  typedef struct packed {
    logic [1:0]  hit_level;
    logic [31:0] value;
    logic        hit;
  } lookup_result_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [95:0] in_tdata = '0;
  logic in_tuser = 1'b0;
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [39:0] out_tdata;
  logic out_tuser;

  // Shadow copy of the cache contents.
  logic [63:0] shadow_key [NumSets * 2];
  logic [31:0] shadow_val [NumSets * 2];
  bit          shadow_valid [NumSets * 2];
  bit          shadow_mru [NumSets];

  lookup_result_t expected_results[$];
  logic [63:0] known_keys[$];
  int error_count = 0;
  int cycle_count = 0;
  int send_idle_pct = 0;
  int recv_idle_pct = 0;

  multilevel_two_way_lookup_cache_top dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata), .in_tuser(in_tuser),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .out_tuser(out_tuser)
  );

  always #4 clk = ~clk;

  // Global set index of a key at one level.
  function automatic int set_index(int lvl, logic [63:0] key);
    int base;
    base = ((8 ** lvl - 1) / 7) << BaseOrder;
    return base + int'(key & ((64'd1 << (BaseOrder + 3 * lvl)) - 1));
  endfunction

  // Probe the levels, promote into shallower levels, and return the result.
  function automatic lookup_result_t predict_lookup(req_kind_t kind, logic [63:0] key,
                                                    logic [31:0] fill_val);
    lookup_result_t r;
    int hit_lvl;
    int hit_way;
    int s;
    int w;
    logic [31:0] v;
    hit_lvl = NumLevels;
    hit_way = 0;
    for (int k = 0; k < NumLevels && hit_lvl == NumLevels; k++) begin
      s = set_index(k, key);
      w = shadow_mru[s];
      if (shadow_valid[2*s+w] && shadow_key[2*s+w] == key) begin
        hit_lvl = k; hit_way = w;
      end else if (shadow_valid[2*s+(w^1)] && shadow_key[2*s+(w^1)] == key) begin
        hit_lvl = k; hit_way = w ^ 1;
      end
    end
    if (hit_lvl == NumLevels && kind == REQ_LOOKUP) begin
      r.hit = 1'b0; r.value = '0; r.hit_level = 2'(NumLevels);
      return r;
    end
    if (hit_lvl < NumLevels) begin
      s = set_index(hit_lvl, key);
      v = shadow_val[2*s+hit_way];
      shadow_mru[s] = hit_way[0];
    end else begin
      v = fill_val;
    end
    for (int k = 0; k < hit_lvl; k++) begin
      s = set_index(k, key);
      w = shadow_mru[s] ^ 1;
      shadow_key[2*s+w] = key;
      shadow_val[2*s+w] = v;
      shadow_valid[2*s+w] = 1'b1;
      shadow_mru[s] = w[0];
    end
    r.hit = (hit_lvl < NumLevels);
    r.value = v;
    r.hit_level = 2'(hit_lvl);
    return r;
  endfunction

  task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
    $display("mismatch %s: got %0h expected %0h at %0t", what, got, want, $realtime);
    error_count++;
  endtask

  // Send one item, predicting its result when it is accepted. The valid stays
  // high after acceptance until the next item or an idle cycle replaces it.
  task automatic send_item(req_kind_t kind, logic [63:0] key, logic [31:0] fill_val);
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser <= kind;
    in_tdata <= {fill_val, key};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    expected_results.push_back(predict_lookup(kind, key, fill_val));
    if (kind == REQ_FILL) known_keys.push_back(key);
    @(negedge clk);
  endtask

  // Result checker.
  always @(posedge clk) begin
    lookup_result_t got;
    lookup_result_t want;
    if (rst_n && out_tvalid && out_tready) begin
      got = out_tdata[34:0];
      if (expected_results.size() == 0) begin
        report_mismatch("unexpected result", 64'(out_tdata), 64'd0);
      end else begin
        want = expected_results.pop_front();
        if (got.hit !== want.hit) report_mismatch("hit", 64'(got.hit), 64'(want.hit));
        if (got.value !== want.value)
          report_mismatch("value", 64'(got.value), 64'(want.value));
        if (got.hit_level !== want.hit_level)
          report_mismatch("hit_level", 64'(got.hit_level), 64'(want.hit_level));
      end
    end
  end

  // Receiver stalls.
  always @(negedge clk) begin
    out_tready <= ($urandom_range(99) >= recv_idle_pct);
  end

  // Watchdog.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  // Pick a key: reuse one, alias a set of a known key, or fresh random.
  function automatic logic [63:0] pick_key();
    logic [63:0] k;
    logic [63:0] mask;
    int sel;
    sel = $urandom_range(9);
    k = {$urandom, $urandom};
    if (known_keys.size() > 0 && sel < 5) begin
      k = known_keys[$urandom_range(known_keys.size() - 1)];
    end else if (known_keys.size() > 0 && sel < 8) begin
      // Same low index bits at some level, so sets fill up and evict.
      mask = (64'd1 << (BaseOrder + 3 * $urandom_range(NumLevels - 1))) - 64'd1;
      k = (k & ~mask) | (known_keys[$urandom_range(known_keys.size() - 1)] & mask);
    end
    return k;
  endfunction

  task automatic test_directed();
    send_item(REQ_LOOKUP, 64'd0, 32'hFFFF_FFFF);
    send_item(REQ_FILL, 64'd0, 32'h0);
    send_item(REQ_LOOKUP, 64'd0, 32'h0);
    send_item(REQ_FILL, '1, '1);
    send_item(REQ_LOOKUP, '1, 32'h0);
    send_item(REQ_FILL, '1, 32'h1234_5678);
    send_item(REQ_FILL, 64'h5555_5555_5555_5555, 32'hAAAA_AAAA);
    send_item(REQ_FILL, 64'hAAAA_AAAA_AAAA_AAAA, 32'h5555_5555);
    // Three keys sharing the level-0 set evict the oldest there, so it then hits at level 1.
    send_item(REQ_FILL, 64'h0000_0000_0000_0040, 32'h11);
    send_item(REQ_FILL, 64'h0000_0000_0000_0080, 32'h22);
    send_item(REQ_FILL, 64'h0000_0000_0000_00C0, 32'h33);
    send_item(REQ_LOOKUP, 64'h0000_0000_0000_0040, 32'h0);
    send_item(REQ_LOOKUP, 64'h0000_0000_0000_0080, 32'h0);
    send_item(REQ_LOOKUP, 64'h0000_0000_0000_00C0, 32'h0);
    send_item(REQ_LOOKUP, 64'h8000_0000_0000_0000, 32'h0);
  endtask

  task automatic test_random(int count);
    for (int i = 0; i < count; i++) begin
      send_item($urandom_range(2) == 0 ? REQ_FILL : REQ_LOOKUP, pick_key(), $urandom);
    end
  endtask

  initial begin
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    test_directed();
    send_idle_pct = 32; recv_idle_pct = 63;
    test_random(470);
    send_idle_pct = 63; recv_idle_pct = 32;
    test_random(470);
    send_idle_pct = 0; recv_idle_pct = 0;
    test_random(460);
    in_tvalid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (error_count == 0 && expected_results.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

[filelist.f]
rtl/mlc_pkg.sv
rtl/mlc_ram.sv
rtl/mlc_level.sv
rtl/mlc_datapath.sv
rtl/mlc_ctrl.sv
rtl/multilevel_two_way_lookup_cache_top.sv
verif/tb_multilevel_two_way_lookup_cache_top.sv
